[hdl/cbc_pkg.sv]
`default_nettype none
package cbc_pkg;

   localparam int NUM_SLICES_DEF   = 18;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int TAB_LEN          = 18;
   localparam int SLICE_W          = 5;
   localparam int ANGLE_LIMIT      = 12868;
   localparam int CUT_LEN          = 19;

   // CORDIC datapath width: |X|,|Y| stay below 2^38, so below 2^54 after the
   // 2^16 prescale; the vector length adds a factor of 1.42 and the rotation
   // gain stays under 1.65, which leaves the magnitude below 2^56.
   localparam int CW = 58;
   localparam int ZW = 27;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EARLY = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   localparam logic [2:0] REG_BBC_FS  = 3'd0;
   localparam logic [2:0] REG_ZDC_FS  = 3'd1;
   localparam logic [2:0] REG_BBC_G   = 3'd2;
   localparam logic [2:0] REG_ZDC_G   = 3'd3;
   localparam logic [2:0] REG_FIRST   = 3'd4;

   typedef struct packed {
      logic [1:0] status;
      logic       check;
   } tag_type;

   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = 27'sd13176795;  1: t = 27'sd7778716;  2: t = 27'sd4110060;
         3: t = 27'sd2086331;   4: t = 27'sd1047214;  5: t = 27'sd524117;
         6: t = 27'sd262123;    7: t = 27'sd131069;   8: t = 27'sd65536;
         9: t = 27'sd32768;    10: t = 27'sd16384;   11: t = 27'sd8192;
         12: t = 27'sd4096;    13: t = 27'sd2048;    14: t = 27'sd1024;
         15: t = 27'sd512;     16: t = 27'sd256;     17: t = 27'sd128;
         18: t = 27'sd64;      19: t = 27'sd32;      20: t = 27'sd16;
         21: t = 27'sd8;       22: t = 27'sd4;       23: t = 27'sd2;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic signed [15:0] cut_val(input int i);
      logic signed [15:0] c;
      case (i)
         0: c = 16'sd12861;  1: c = 16'sd9896;   2: c = 16'sd8585;  3: c = 16'sd7537;
         4: c = 16'sd6645;   5: c = 16'sd5833;   6: c = 16'sd5046;  7: c = 16'sd4207;
         8: c = 16'sd3369;   9: c = 16'sd2556;  10: c = 16'sd1717; 11: c = 16'sd931;
         12: c = 16'sd223;  13: c = -16'sd433;  14: c = -16'sd1035;
         15: c = -16'sd1612; 16: c = -16'sd2241; 17: c = -16'sd3342;
         default: c = -16'sd12861;
      endcase
      return c;
   endfunction

   function automatic logic [11:0] npart_val(input logic [SLICE_W-1:0] s);
      logic [11:0] v;
      case (s)
         5'd0: v = 12'd3467;  5'd1: v = 12'd2928;  5'd2: v = 12'd2487;
         5'd3: v = 12'd2102;  5'd4: v = 12'd1767;  5'd5: v = 12'd1481;
         5'd6: v = 12'd1227;  5'd7: v = 12'd1003;  5'd8: v = 12'd814;
         5'd9: v = 12'd641;   5'd10: v = 12'd494;  5'd11: v = 12'd381;
         5'd12: v = 12'd287;  5'd13: v = 12'd212;  5'd14: v = 12'd153;
         5'd15: v = 12'd109;  5'd16: v = 12'd77;   5'd17: v = 12'd55;
         default: v = 12'd30;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] ncoll_val(input logic [SLICE_W-1:0] s);
      logic [13:0] v;
      case (s)
         5'd0: v = 14'd9452;  5'd1: v = 14'd7486;  5'd2: v = 14'd5982;
         5'd3: v = 14'd4766;  5'd4: v = 14'd3771;  5'd5: v = 14'd2952;
         5'd6: v = 14'd2280;  5'd7: v = 14'd1729;  5'd8: v = 14'd1299;
         5'd9: v = 14'd936;   5'd10: v = 14'd658;  5'd11: v = 14'd464;
         5'd12: v = 14'd320;  5'd13: v = 14'd216;  5'd14: v = 14'd143;
         5'd15: v = 14'd94;   5'd16: v = 14'd61;   5'd17: v = 14'd41;
         default: v = 14'd20;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[hdl/cbc_front.sv]
`default_nettype none
// Front end: gain products, then the two normalised coordinates.
module cbc_front import cbc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic [16:0]          bbc_sum,
   input  wire logic [16:0]          zdc_sum,
   input  wire logic [11:0]          bbc_gain,
   input  wire logic [11:0]          zdc_gain,
   input  wire logic [11:0]          bbc_fs,
   input  wire logic [13:0]          zdc_fs,
   input  wire tag_type              in_tag,
   output logic                      out_valid,
   output tag_type                   out_tag,
   output logic signed [CW-1:0]      x_out,
   output logic signed [CW-1:0]      y_out,
   output logic                      origin
);
   logic        v1_ff, v2_ff;
   tag_type     t1_ff, t2_ff;
   logic [28:0] bp_ff, ep_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic        o_ff;
   logic [11:0] bfs;
   logic [13:0] zfs;
   logic [20:0] bsum, esum;
   logic signed [24:0] ynum;
   logic [27:0] e20;
   logic signed [38:0] ymul;
   logic [39:0] xmul;

   assign bfs  = (bbc_fs == '0) ? 12'd1 : bbc_fs;
   assign zfs  = (zdc_fs == '0) ? 14'd1 : zdc_fs;
   assign bsum = bp_ff[28:8];
   assign esum = ep_ff[28:8];
   assign ynum = $signed({1'b0, 24'(bsum) * 24'd5}) - $signed({9'd0, bfs, 4'd0});
   assign e20  = 28'(esum) * 28'd20;
   assign ymul = 39'(ynum) * $signed({25'd0, zfs});
   assign xmul = 40'(e20) * 40'(bfs);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         t1_ff <= in_tag;
         bp_ff <= 29'(bbc_sum) * 29'(bbc_gain);
         ep_ff <= 29'(zdc_sum) * 29'(zdc_gain);
         t2_ff <= t1_ff;
         x_ff  <= $signed({{(CW-56){1'b0}}, xmul, 16'd0});
         y_ff  <= $signed({{(CW-55){ymul[38]}}, ymul, 16'd0});
         o_ff  <= (esum == '0) && (ynum == '0);
      end
   end

   assign out_valid = v2_ff;
   assign out_tag   = t2_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign origin    = o_ff;
endmodule
`default_nettype wire

[hdl/cbc_cordic.sv]
`default_nettype none
// Pipelined vectoring CORDIC, one rotation per stage, then round and clamp.
module cbc_cordic import cbc_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire tag_type              in_tag,
   input  wire logic signed [CW-1:0] x_in,
   input  wire logic signed [CW-1:0] y_in,
   input  wire logic                 origin,
   output logic                      out_valid,
   output tag_type                   out_tag,
   output logic signed [14:0]        angle
);
   localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   logic                 v_ff [N+1];
   tag_type              t_ff [N+1];
   logic                 o_ff [N+1];
   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic                 vo_ff;
   tag_type              to_ff;
   logic signed [14:0]   a_ff;
   logic signed [ZW-1:0] zr;
   logic signed [ZW-12:0] q;

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= in_valid;
      if (adv) begin
         t_ff[0] <= in_tag;
         o_ff[0] <= origin;
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (adv) v_ff[i+1] <= v_ff[i];
         if (adv) begin
            t_ff[i+1] <= t_ff[i];
            o_ff[i+1] <= o_ff[i];
            if (!y_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_val(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_val(i);
            end
         end
      end
   end

   assign zr = z_ff[N] + ZW'(1024);
   assign q  = zr[ZW-1:11];

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (adv) vo_ff <= v_ff[N];
      if (adv) begin
         to_ff <= t_ff[N];
         if (o_ff[N]) a_ff <= '0;
         else if (q > (ZW-11)'(ANGLE_LIMIT)) a_ff <= 15'(ANGLE_LIMIT);
         else if (q < -(ZW-11)'(ANGLE_LIMIT)) a_ff <= -15'(ANGLE_LIMIT);
         else a_ff <= q[14:0];
      end
   end

   assign out_valid = vo_ff;
   assign out_tag   = to_ff;
   assign angle     = a_ff;
endmodule
`default_nettype wire

[hdl/cbc_slice.sv]
`default_nettype none
// Slice search against the cut table, then the count lookup.
module cbc_slice import cbc_pkg::*; #(
   parameter int NUM_SLICES = NUM_SLICES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire tag_type           in_tag,
   input  wire logic signed [14:0] angle_in,
   output logic                   out_valid,
   output logic [1:0]             status,
   output logic [SLICE_W-1:0]     cent_slice,
   output logic signed [14:0]     angle,
   output logic [11:0]            npart,
   output logic [13:0]            ncoll
);
   logic [NUM_SLICES-1:0] hit;
   logic [NUM_SLICES-1:0] h_ff;
   logic                  v1_ff, v2_ff;
   tag_type               t1_ff;
   logic signed [14:0]    a1_ff, a2_ff;
   logic [1:0]            s_ff;
   logic [SLICE_W-1:0]    c_ff;
   logic [11:0]           np_ff;
   logic [13:0]           nc_ff;
   logic [SLICE_W-1:0]    idx;
   logic                  found;

   for (genvar j = 0; j < NUM_SLICES; j++) begin : g_cmp
      localparam int HI = (j < CUT_LEN) ? j : CUT_LEN - 1;
      localparam int LO = (j + 1 < CUT_LEN) ? j + 1 : CUT_LEN - 1;
      assign hit[j] = ($signed({angle_in[14], angle_in}) > cut_val(LO)) &&
                      ($signed({angle_in[14], angle_in}) < cut_val(HI));
   end

   always_comb begin
      idx   = '0;
      found = 1'b0;
      for (int j = 0; j < NUM_SLICES; j++) begin
         if (h_ff[j]) begin
            idx   = SLICE_W'(j);
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         h_ff  <= hit;
         t1_ff <= in_tag;
         a1_ff <= angle_in;
         a2_ff <= a1_ff;
         if (!t1_ff.check) begin
            s_ff <= t1_ff.status; c_ff <= '0; np_ff <= '0; nc_ff <= '0;
         end else if (!found) begin
            s_ff <= ST_NONE; c_ff <= '0; np_ff <= '0; nc_ff <= '0;
         end else begin
            s_ff <= ST_OK; c_ff <= idx;
            np_ff <= npart_val(idx); nc_ff <= ncoll_val(idx);
         end
      end
   end

   assign out_valid  = v2_ff;
   assign status     = s_ff;
   assign cent_slice = c_ff;
   assign angle      = a2_ff;
   assign npart      = np_ff;
   assign ncoll      = nc_ff;
endmodule
`default_nettype wire

[hdl/centrality_bin_classifier_unit.sv]
`default_nettype none
// Centrality slice classifier. Each request carries a run number, two beam
// counter charges and two zero-degree energies; one response comes back per
// request, in order, giving status, slice, angle and the tabulated counts.
// The pipeline takes one request per clock when rsp_stall is low; its stages
// are two product stages, the CORDIC input register, one stage per CORDIC
// rotation, a round and clamp stage, and two slice stages, the second of which
// is the output register. A stall freezes the whole pipeline, so req_stall
// simply follows rsp_stall while the output register is full. Configuration
// is written through the csr_ port.
module centrality_bin_classifier_unit import cbc_pkg::*; #(
   parameter int NUM_SLICES   = NUM_SLICES_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [19:0] req_run_number,
   input  wire logic [15:0] req_bbc_south,
   input  wire logic [15:0] req_bbc_north,
   input  wire logic [15:0] req_zdc_south,
   input  wire logic [15:0] req_zdc_north,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_cent_slice,
   output logic signed [14:0] rsp_angle,
   output logic [11:0]      rsp_npart_tenths,
   output logic [13:0]      rsp_ncoll_tenths,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   logic [11:0] bbc_fs_ff, bbc_g_ff, zdc_g_ff;
   logic [13:0] zdc_fs_ff;
   logic [19:0] first_ff;
   logic        adv;
   tag_type     tag_in, tag_f, tag_c;
   logic        v_f, v_c, origin;
   logic signed [CW-1:0] x_f, y_f;
   logic signed [14:0] ang_c;

   // The whole pipeline moves together; it only holds when a result waits.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bbc_fs_ff <= 12'd400;
         zdc_fs_ff <= 14'd4500;
         bbc_g_ff  <= 12'd256;
         zdc_g_ff  <= 12'd256;
         first_ff  <= 20'd8884;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BBC_FS: bbc_fs_ff <= csr_wdata[11:0];
            REG_ZDC_FS: zdc_fs_ff <= csr_wdata[13:0];
            REG_BBC_G:  bbc_g_ff  <= csr_wdata[11:0];
            REG_ZDC_G:  zdc_g_ff  <= csr_wdata[11:0];
            REG_FIRST:  first_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Status decided up front: a zero south energy wins over an early run.
   always_comb begin
      if (req_zdc_south == '0) begin
         tag_in.status = ST_ZERO; tag_in.check = 1'b0;
      end else if (req_run_number < first_ff) begin
         tag_in.status = ST_EARLY; tag_in.check = 1'b0;
      end else begin
         tag_in.status = ST_OK; tag_in.check = 1'b1;
      end
   end

   cbc_front u_front (
      .clock, .reset, .adv,
      .in_valid (req_valid && adv),
      .bbc_sum  (17'(req_bbc_south) + 17'(req_bbc_north)),
      .zdc_sum  (17'(req_zdc_south) + 17'(req_zdc_north)),
      .bbc_gain (bbc_g_ff), .zdc_gain (zdc_g_ff),
      .bbc_fs   (bbc_fs_ff), .zdc_fs (zdc_fs_ff),
      .in_tag   (tag_in),
      .out_valid (v_f), .out_tag (tag_f),
      .x_out (x_f), .y_out (y_f), .origin (origin)
   );

   cbc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .adv,
      .in_valid (v_f), .in_tag (tag_f),
      .x_in (x_f), .y_in (y_f), .origin (origin),
      .out_valid (v_c), .out_tag (tag_c), .angle (ang_c)
   );

   cbc_slice #(.NUM_SLICES(NUM_SLICES)) u_slice (
      .clock, .reset, .adv,
      .in_valid (v_c), .in_tag (tag_c), .angle_in (ang_c),
      .out_valid (rsp_valid), .status (rsp_status),
      .cent_slice (rsp_cent_slice), .angle (rsp_angle),
      .npart (rsp_npart_tenths), .ncoll (rsp_ncoll_tenths)
   );
endmodule
`default_nettype wire
